[rtl/sparse_led_frame_expander_defines.svh]
`ifndef SPARSE_LED_FRAME_EXPANDER_DEFINES_SVH
`define SPARSE_LED_FRAME_EXPANDER_DEFINES_SVH

// property checked on every clock outside reset
`define SLFE_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// signal keeps its value into the cycle after cond
`define SLFE_ASSERT_HOLD(name, cond, sig, msg) \
    `SLFE_ASSERT(name, (cond) |=> $stable(sig), msg)

`endif

[rtl/slfe_pkg.sv]
package slfe_pkg;

    localparam int POS_W       = 12;
    localparam int CNT_W       = 9;
    localparam int COLOR_W     = 8;
    localparam int SLOT_W      = 8;
    localparam int CHAN_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CHAN_W-1:0] LIT_CHANNEL = 8'd1;

    typedef enum logic [1:0] {
        CMD_WR_SOLID,
        CMD_WR_FLASH,
        CMD_START,
        CMD_PULL
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL,
        CFG_SOLID_COUNT,
        CFG_FLASH_COUNT
    } t_cfg_idx;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_rgb;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             lit;
        t_rgb             rgb;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        t_entry            entry;
    } t_wr_req;

endpackage

[rtl/slfe_ram.sv]
module slfe_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/slfe_lane.sv]
module slfe_lane
    import slfe_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_wr_req          i_wr,
    input  logic             i_start,
    input  logic             i_pull,
    input  logic [CNT_W-1:0] i_count,
    input  logic [POS_W-1:0] i_position,
    output t_rgb             o_rgb
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [CNT_W-1:0] r_cursor;
    logic [CNT_W-1:0] n_cursor;
    t_entry           w_head;
    logic             w_we;
    logic             w_hit;

    assign w_we = i_wr.en && (32'(i_wr.slot) < MAX_ENTRIES);

    // head entry always sits at the cursor: read address is the next cursor
    slfe_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_wr.slot)),
        .i_wdata (i_wr.entry),
        .i_raddr (AW'(n_cursor)),
        .o_rdata (w_head)
    );

    assign w_hit = (32'(r_cursor) < MAX_ENTRIES) && (r_cursor < i_count)
                 && w_head.lit && (w_head.position == i_position);

    assign o_rgb = w_hit ? w_head.rgb : '0;

    always_comb begin
        n_cursor = r_cursor;
        if (i_start) begin
            n_cursor = '0;
        end else if (i_pull && w_hit) begin
            n_cursor = r_cursor + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else begin
            r_cursor <= n_cursor;
        end
    end

endmodule

[rtl/sparse_led_frame_expander.sv]
// an item is registered at the input stage, worked on there and its word is then registered
// in the output stage; while the output stalls, a pull item waits in the input stage
// throughput: one item per cycle unless stalled; each list ram gives one read per cycle at its cursor
// reset: synchronous, active low; clears config registers, cursors, position, phase and valids
// list tables are not cleared and hold garbage until written
module sparse_led_frame_expander
    import slfe_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // entry_index, entry_position, entry_channel, entry_red, entry_green,
    // entry_blue, phase, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // red, green, blue, position, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic [POS_W-1:0]   r_total;
    logic [CNT_W-1:0]   r_solid_cnt;
    logic [CNT_W-1:0]   r_flash_cnt;

    logic               r_in_valid;
    t_cmd               r_in_cmd;
    logic [SLOT_W-1:0]  r_in_slot;
    t_entry             r_in_entry;
    logic               r_in_phase;

    logic [POS_W-1:0]   r_pos;
    logic               r_phase;

    logic               r_out_valid;
    t_rgb               r_out_rgb;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_last;

    logic               w_is_wr_solid;
    logic               w_is_wr_flash;
    logic               w_is_start;
    logic               w_is_pull;
    logic               w_produce;
    logic               w_adv;
    logic               w_last;
    t_wr_req            w_wr_solid;
    t_wr_req            w_wr_flash;
    t_rgb               w_solid_rgb;
    t_rgb               w_flash_rgb;
    t_rgb               w_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_solid_cnt <= '0;
            r_flash_cnt <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TOTAL:       r_total     <= i_cfg_data[POS_W-1:0];
                CFG_SOLID_COUNT: r_solid_cnt <= i_cfg_data[CNT_W-1:0];
                CFG_FLASH_COUNT: r_flash_cnt <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // command decode
    always_comb begin
        w_is_wr_solid = 1'b0;
        w_is_wr_flash = 1'b0;
        w_is_start    = 1'b0;
        w_is_pull     = 1'b0;
        unique case (r_in_cmd)
            CMD_WR_SOLID: w_is_wr_solid = 1'b1;
            CMD_WR_FLASH: w_is_wr_flash = 1'b1;
            CMD_START:    w_is_start    = 1'b1;
            CMD_PULL:     w_is_pull     = 1'b1;
            default: ;
        endcase
    end

    assign w_produce = w_is_pull && (r_pos < r_total);
    assign w_adv     = r_in_valid && (!w_produce || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd            <= t_cmd'(s_axis_tuser[1:0]);
            r_in_slot           <= s_axis_tdata[7:0];
            r_in_entry.position <= s_axis_tdata[19:8];
            r_in_entry.lit      <= (s_axis_tdata[27:20] == LIT_CHANNEL);
            r_in_entry.rgb.red  <= s_axis_tdata[35:28];
            r_in_entry.rgb.green <= s_axis_tdata[43:36];
            r_in_entry.rgb.blue <= s_axis_tdata[51:44];
            r_in_phase          <= s_axis_tdata[52];
        end
    end

    assign w_wr_solid = '{en: w_adv && w_is_wr_solid, slot: r_in_slot, entry: r_in_entry};
    assign w_wr_flash = '{en: w_adv && w_is_wr_flash, slot: r_in_slot, entry: r_in_entry};

    slfe_lane #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_solid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_wr_solid),
        .i_start    (w_adv && w_is_start),
        .i_pull     (w_adv && w_produce && !r_phase),
        .i_count    (r_solid_cnt),
        .i_position (r_pos),
        .o_rgb      (w_solid_rgb)
    );

    slfe_lane #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_flash (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_wr_flash),
        .i_start    (w_adv && w_is_start),
        .i_pull     (w_adv && w_produce && r_phase),
        .i_count    (r_flash_cnt),
        .i_position (r_pos),
        .o_rgb      (w_flash_rgb)
    );

    assign w_rgb  = r_phase ? w_flash_rgb : w_solid_rgb;
    assign w_last = ({1'b0, r_pos} + (POS_W + 1)'(1)) == {1'b0, r_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= 1'b0;
        end else if (w_adv && w_is_start) begin
            r_pos   <= '0;
            r_phase <= r_in_phase;
        end else if (w_adv && w_produce) begin
            r_pos   <= r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_produce) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_produce) begin
            r_out_rgb  <= w_rgb;
            r_out_pos  <= r_pos;
            r_out_last <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_pos, r_out_rgb.blue, r_out_rgb.green, r_out_rgb.red};
    assign m_axis_tlast  = r_out_last;

endmodule

[rtl/slfe_checker.sv]
`include "sparse_led_frame_expander_defines.svh"

module slfe_checker
    import slfe_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_wr_en,
    input logic [CFG_IDX_W-1:0]   i_cfg_index,
    input logic [CFG_DATA_W-1:0]  i_cfg_data,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    logic [POS_W-1:0] r_total;
    logic [POS_W-1:0] w_pos;
    logic             w_pull_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cfg_wr_en && (i_cfg_index == CFG_TOTAL)) begin
            r_total <= i_cfg_data[POS_W-1:0];
        end
    end

    assign w_pos      = m_axis_tdata[35:24];
    assign w_pull_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_PULL);

    `SLFE_ASSERT(a_pos_in_frame, m_axis_tvalid |-> (w_pos < r_total), "word position past frame")
    `SLFE_ASSERT(a_last_marks_end, m_axis_tvalid |-> (m_axis_tlast == (({1'b0, w_pos} + (POS_W + 1)'(1)) == {1'b0, r_total})), "tlast does not match final position")
    `SLFE_ASSERT(a_word_from_pull, $rose(m_axis_tvalid) |-> $past(w_pull_acc, 2), "word without a pull item")
    `SLFE_ASSERT_HOLD(a_stall_hold, m_axis_tvalid && !m_axis_tready, {m_axis_tvalid, m_axis_tdata, m_axis_tlast}, "stalled word changed")

endmodule

bind sparse_led_frame_expander slfe_checker u_slfe_checker (.*);
